// ===== hw/rtl/duplicate_packet_filter_core_macros.svh =====
// ----------------------------------------------------------------------------
// Duplicate packet filter assertion macros
// Shared concurrent assertion forms for the duplicate packet filter core.
// ----------------------------------------------------------------------------
`ifndef DUPLICATE_PACKET_FILTER_CORE_MACROS_SVH
`define DUPLICATE_PACKET_FILTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/dpf_pkg.sv =====
// ----------------------------------------------------------------------------
// Duplicate packet filter package
// Field widths and the entry and control types shared by the filter modules.
// ----------------------------------------------------------------------------
package dpf_pkg;

	localparam int ADDR_W     = 16;
	localparam int SEQ_W      = 8;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 2;

	localparam logic [ADDR_W-1:0] BROADCAST_ADDR = '0;

	// Byte address of the local address register.
	localparam logic [APB_ADDR_W-1:0] REG_LOCAL_ADDRESS = '0;

	// One stored sender and the last sequence number accepted from it.
	typedef struct packed {
		logic [ADDR_W-1:0] sender;
		logic [SEQ_W-1:0]  seq;
	} entry_t;

	// Chain control: shift moves every cell, insert selects the direction
	// toward the oldest end (new entry enters at the head).
	typedef struct packed {
		logic shift;
		logic insert;
	} chain_ctl_t;

endpackage

// ===== hw/rtl/dpf_in_if.sv =====
// ----------------------------------------------------------------------------
// Duplicate packet filter input channel
// Valid/ready channel that carries one packet header word.
// ----------------------------------------------------------------------------
interface dpf_in_if;
	logic                         valid;
	logic                         ready;
	logic [dpf_pkg::ADDR_W-1:0]   sender;
	logic [dpf_pkg::SEQ_W-1:0]    seq_number;
	logic [dpf_pkg::ADDR_W-1:0]   receiver;
	logic                         is_master_msg;

	modport source (output valid, sender, seq_number, receiver, is_master_msg, input ready);
	modport sink (input valid, sender, seq_number, receiver, is_master_msg, output ready);
endinterface

// ===== hw/rtl/dpf_out_if.sv =====
// ----------------------------------------------------------------------------
// Duplicate packet filter output channel
// Valid/ready channel that carries one verdict word.
// ----------------------------------------------------------------------------
interface dpf_out_if;
	logic valid;
	logic ready;
	logic fresh;
	logic master_changed;

	modport source (output valid, fresh, master_changed, input ready);
	modport sink (input valid, fresh, master_changed, output ready);
endinterface

// ===== hw/rtl/duplicate_packet_filter_core.sv =====
// ----------------------------------------------------------------------------
// Duplicate packet filter core
// Flags repeated packet headers per sender using a master record and a chain
// of recently seen senders.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Word
//  in_ch     in         valid/ready           sender, seq_number, receiver,
//                                             is_master_msg
//  out_ch    out        valid/ready           fresh, master_changed
//  APB       in         psel/penable/pready   local_address at byte 0
//
//  A header that hits the master record or takes over the master role is
//  answered without moving the chain; any other header rotates the whole
//  chain once and is inserted at the head if its sender was not found.
//  The input is accepted only when the sequencer is idle; a finished word
//  waits in the output register, and the next one stalls until it is taken.
//  Reset clears the master record and every cache cell at once.
// ----------------------------------------------------------------------------
`include "duplicate_packet_filter_core_macros.svh"

module duplicate_packet_filter_core #(
	parameter int CACHE_DEPTH = 16,
	parameter int SHADOW_SPAN = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dpf_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [dpf_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [dpf_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	dpf_in_if.sink                          in_ch,
	dpf_out_if.source                       out_ch
);

	logic [dpf_pkg::ADDR_W-1:0] local_address_q;
	dpf_pkg::entry_t            cell_entry [CACHE_DEPTH];
	dpf_pkg::entry_t            tap_back;
	dpf_pkg::entry_t            new_entry;
	dpf_pkg::chain_ctl_t        ctl;

	// Only one register exists, so reads return it at every address.
	assign pready = 1'b1;
	assign prdata = {{(dpf_pkg::APB_DATA_W - dpf_pkg::ADDR_W){1'b0}}, local_address_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_address_q <= '0;
		end else if (psel && penable && pwrite && (paddr == dpf_pkg::REG_LOCAL_ADDRESS)) begin
			local_address_q <= pwdata[dpf_pkg::ADDR_W-1:0];
		end
	end

	dpf_ctrl #(
		.CACHE_DEPTH (CACHE_DEPTH),
		.SHADOW_SPAN (SHADOW_SPAN)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (in_ch),
		.out_ch        (out_ch),
		.local_address (local_address_q),
		.tap           (cell_entry[0]),
		.tap_back      (tap_back),
		.new_entry     (new_entry),
		.ctl           (ctl)
	);

	// Cell 0 holds the newest sender, the last cell the oldest.
	for (genvar k = 0; k < CACHE_DEPTH; k++) begin : g_cell
		dpf_pkg::entry_t left_in;
		dpf_pkg::entry_t right_in;

		if (k == 0) begin : g_head
			assign left_in = new_entry;
		end else begin : g_body_l
			assign left_in = cell_entry[k-1];
		end

		if (k == CACHE_DEPTH - 1) begin : g_tail
			assign right_in = tap_back;
		end else begin : g_body_r
			assign right_in = cell_entry[k+1];
		end

		dpf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.left_in  (left_in),
			.right_in (right_in),
			.entry    (cell_entry[k])
		);
	end

	`DPF_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "input accepted while busy")
	`DPF_ASSERT_SAME(a_chain_still_idle, clk, arst_n, in_ch.ready, !ctl.shift, "chain moved while idle")
	`DPF_ASSERT_NEXT(a_insert_at_head, clk, arst_n, ctl.insert, cell_entry[0] == $past(new_entry), "insert missed head cell")

endmodule

// ===== hw/rtl/dpf_cell.sv =====
// ----------------------------------------------------------------------------
// Duplicate packet filter cache cell
// One entry of the sender cache; takes a neighbor's entry on each shift.
// ----------------------------------------------------------------------------
module dpf_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  dpf_pkg::chain_ctl_t ctl,
	input  dpf_pkg::entry_t     left_in,
	input  dpf_pkg::entry_t     right_in,
	output dpf_pkg::entry_t     entry
);

	dpf_pkg::entry_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (ctl.shift) begin
			entry_q <= ctl.insert ? left_in : right_in;
		end
	end

	assign entry = entry_q;

endmodule

// ===== hw/rtl/dpf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Duplicate packet filter sequencer
// Holds the master record, decides each header and steers the cache chain.
// ----------------------------------------------------------------------------
module dpf_ctrl #(
	parameter int CACHE_DEPTH = 16,
	parameter int SHADOW_SPAN = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	dpf_in_if.sink                      in_ch,
	dpf_out_if.source                   out_ch,
	input  logic [dpf_pkg::ADDR_W-1:0]  local_address,
	input  dpf_pkg::entry_t             tap,
	output dpf_pkg::entry_t             tap_back,
	output dpf_pkg::entry_t             new_entry,
	output dpf_pkg::chain_ctl_t         ctl
);

	localparam int CNT_W = $clog2(CACHE_DEPTH);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CACHE_DEPTH - 1);
	localparam logic [dpf_pkg::SEQ_W-1:0] SPAN = dpf_pkg::SEQ_W'(SHADOW_SPAN);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SCAN,
		ST_INSERT,
		ST_DONE
	} state_t;

	state_t                      state_q;
	logic [CNT_W-1:0]            step_q;
	logic                        found_q;
	logic                        fresh_q;
	logic                        changed_q;
	logic                        out_valid_q;
	logic                        out_fresh_q;
	logic                        out_changed_q;
	logic [dpf_pkg::ADDR_W-1:0]  master_addr_q;
	logic [dpf_pkg::SEQ_W-1:0]   master_seq_q;
	logic [dpf_pkg::ADDR_W-1:0]  sender_q;
	logic [dpf_pkg::SEQ_W-1:0]   seq_q;
	logic [dpf_pkg::ADDR_W-1:0]  receiver_q;
	logic                        is_master_q;

	logic hit;
	logic hit_dup;
	logic master_dup;

	function automatic logic seq_is_stale(input logic [dpf_pkg::SEQ_W-1:0] stored,
	                                      input logic [dpf_pkg::SEQ_W-1:0] seq);
		logic [dpf_pkg::SEQ_W-1:0] diff;
		diff = stored - seq;
		return diff < SPAN;
	endfunction

	// The chain rotates one place per scan step, so cell 0 shows the entries
	// newest first; the last step brings back the oldest entry unsearched.
	always_comb begin
		hit        = (state_q == ST_SCAN) && (step_q != LAST_STEP) && !found_q &&
		             (tap.sender == sender_q);
		hit_dup    = seq_is_stale(tap.seq, seq_q);
		master_dup = seq_is_stale(master_seq_q, seq_q);
		tap_back   = tap;
		if (hit && !hit_dup) begin
			tap_back.seq = seq_q;
		end
		new_entry.sender = sender_q;
		new_entry.seq    = seq_q;
		ctl.shift        = (state_q == ST_SCAN) || (state_q == ST_INSERT);
		ctl.insert       = (state_q == ST_INSERT);
	end

	assign in_ch.ready           = (state_q == ST_IDLE);
	assign out_ch.valid          = out_valid_q;
	assign out_ch.fresh          = out_fresh_q;
	assign out_ch.master_changed = out_changed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= '0;
			found_q       <= 1'b0;
			fresh_q       <= 1'b1;
			changed_q     <= 1'b0;
			out_valid_q   <= 1'b0;
			out_fresh_q   <= 1'b0;
			out_changed_q <= 1'b0;
			master_addr_q <= '0;
			master_seq_q  <= '0;
			sender_q      <= '0;
			seq_q         <= '0;
			receiver_q    <= '0;
			is_master_q   <= 1'b0;
		end else begin
			// In ST_DONE the output register is refilled in the same cycle.
			if (out_valid_q && out_ch.ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						sender_q    <= in_ch.sender;
						seq_q       <= in_ch.seq_number;
						receiver_q  <= in_ch.receiver;
						is_master_q <= in_ch.is_master_msg;
						state_q     <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					step_q    <= '0;
					found_q   <= 1'b0;
					fresh_q   <= 1'b1;
					changed_q <= 1'b0;
					if (sender_q == master_addr_q) begin
						if (master_dup) begin
							fresh_q <= 1'b0;
						end else begin
							master_seq_q <= seq_q;
						end
						state_q <= ST_DONE;
					end else if (is_master_q && ((receiver_q == dpf_pkg::BROADCAST_ADDR) ||
					                             (receiver_q == local_address))) begin
						master_addr_q <= sender_q;
						master_seq_q  <= seq_q;
						changed_q     <= 1'b1;
						state_q       <= ST_DONE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						found_q <= 1'b1;
						fresh_q <= !hit_dup;
					end
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						state_q <= found_q ? ST_DONE : ST_INSERT;
					end
				end
				ST_INSERT: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q   <= 1'b1;
						out_fresh_q   <= fresh_q;
						out_changed_q <= changed_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
